>>> rtl/core/kmc_pkg.sv
// kmc_pkg: types and constants shared by the k-means clustering block.
// Depends on nothing; kmeans_clustering_top takes everything by scoped name.
package kmc_pkg;

	localparam int COORD_W    = 16;
	localparam int SHARE_W    = 14;
	localparam int SHARE_SCALE = 10000;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd4;

	localparam logic [10:0] RST_NUM_POINTS     = 11'd16;
	localparam logic [3:0]  RST_NUM_DIMS       = 4'd2;
	localparam logic [3:0]  RST_NUM_CLUSTERS   = 4'd4;
	localparam logic [15:0] RST_MAX_ITERATIONS = 16'd1000;
	localparam logic [14:0] RST_TOLERANCE      = 15'd0;

	typedef struct packed {
		logic signed [COORD_W-1:0] coordinate;
		logic                      last_coordinate;
	} in_t;

	typedef struct packed {
		logic [2:0]                cluster_index;
		logic [2:0]                dim_index;
		logic signed [COORD_W-1:0] centroid_value;
		logic [SHARE_W-1:0]        share_hundredths;
		logic                      is_most_frequent;
		logic                      last_result;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SEED_RD,
		S_SEED_WR,
		S_ITER,
		S_ASG_RD,
		S_ASG_MUL,
		S_ASG_ACC,
		S_CLR,
		S_ACC_RD,
		S_ACC_LAB,
		S_ACC_RD2,
		S_ACC_WR,
		S_UPD_RD,
		S_UPD_CHK,
		S_DIV,
		S_UPD_WR,
		S_BEST,
		S_OUT_SH,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_WAIT
	} state_t;

endpackage

>>> rtl/core/kmeans_clustering_top.sv
// kmeans_clustering_top: Lloyd k-means over a stored point set, one shared
// sequencer with a square unit and a shift-subtract divider. Uses kmc_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  in       | in_valid / in_stall   | kmc_pkg::in_t, one coordinate per beat
//  out      | out_valid / out_stall | kmc_pkg::out_t, one centroid coord/beat
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (ready always high)
//
// Loading accepts one coordinate beat per cycle while in_stall is low. The beat
// flagged last starts a run; in_stall stays high until the last result beat is taken.
// Per iteration: one square per point, cluster and coordinate (states ASG_RD,
// ASG_MUL, ASG_ACC), then clearing of the sums, accumulating, and a divide per
// coordinate of each non-empty cluster. Output divides once per cluster for the
// share, then hands out each coordinate, waiting out any out_stall.
// Reset puts the sequencer idle with the reset register values; the point
// store holds nothing meaningful until written.
module kmeans_clustering_top #(
	parameter int MAX_POINTS   = 1024,
	parameter int MAX_DIMS     = 8,
	parameter int MAX_CLUSTERS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  kmc_pkg::in_t                        in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output kmc_pkg::out_t                       out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW    = kmc_pkg::COORD_W;
	localparam int PTS_W = $clog2(MAX_POINTS + 1);
	localparam int PI_W  = $clog2(MAX_POINTS);
	localparam int DN_W  = $clog2(MAX_DIMS + 1);
	localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int LB_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int DEPTH = MAX_POINTS * MAX_DIMS;
	localparam int AD_W  = $clog2(DEPTH);
	localparam int LP_W  = $clog2(DEPTH + 1);
	localparam int CD    = MAX_CLUSTERS * MAX_DIMS;
	localparam int CA_W  = (CD > 1) ? $clog2(CD) : 1;
	localparam int SUM_W = CW + PTS_W;
	localparam int SQ_W  = 2 * CW + 2;
	localparam int DIST_W = SQ_W + DN_W;
	localparam int DIV_W = (SUM_W > PTS_W + kmc_pkg::SHARE_W) ? SUM_W
		: PTS_W + kmc_pkg::SHARE_W;
	localparam int DC_W  = $clog2(DIV_W);

	// configuration registers
	logic [10:0] cfg_np_q;
	logic [3:0]  cfg_nd_q;
	logic [3:0]  cfg_nc_q;
	logic [15:0] cfg_mi_q;
	logic [14:0] cfg_tol_q;

	kmc_pkg::state_t state_q, state_d;

	// run parameters, latched at the start of a run
	logic [PTS_W-1:0] np_q;
	logic [PI_W-1:0]  np_m1_q;
	logic [DN_W-1:0]  nd_q;
	logic [DI_W-1:0]  nd_m1_q;
	logic [LB_W-1:0]  nc_m1_q;
	logic [CA_W-1:0]  nk_m1_q;
	logic [16:0]      limit_q;

	logic [LP_W-1:0]  lp_q;
	logic [15:0]      iter_q;
	logic [PI_W-1:0]  i_q;
	logic [AD_W-1:0]  pb_q;
	logic [LB_W-1:0]  c_q;
	logic [DI_W-1:0]  d_q;
	logic [CA_W-1:0]  ca_q;
	logic [CA_W-1:0]  k_q;
	logic [CA_W-1:0]  lb_q;
	logic [DIST_W-1:0] dist_q;
	logic [DIST_W-1:0] best_q;
	logic [LB_W-1:0]  lab_q;
	logic [SQ_W-1:0]  prod_q;
	logic             conv_q;
	logic             zero_q;
	logic             neg_q;
	logic             div_share_q;
	logic [DIV_W-1:0] dq_q;
	logic [PTS_W-1:0] rem_q;
	logic [PTS_W-1:0] den_q;
	logic [DC_W-1:0]  dcnt_q;
	logic [PTS_W-1:0] best_n_q;
	logic [LB_W-1:0]  best_c_q;
	logic [PTS_W-1:0] cnt_q [MAX_CLUSTERS];
	kmc_pkg::out_t    out_q;
	logic             out_valid_q;

	// memories
	logic signed [CW-1:0]    store_mem [DEPTH];
	logic [LB_W-1:0]         lbl_mem [MAX_POINTS];
	logic signed [CW-1:0]    cent_mem [CD];
	logic signed [SUM_W-1:0] sum_mem [CD];
	logic signed [CW-1:0]    store_rd_q;
	logic [LB_W-1:0]         lbl_rd_q;
	logic signed [CW-1:0]    cent_rd_q;
	logic signed [SUM_W-1:0] sum_rd_q;

	logic in_acc, cfg_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_acc = out_valid_q && !out_stall;

	assign in_stall  = (state_q != kmc_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_np_q  <= kmc_pkg::RST_NUM_POINTS;
			cfg_nd_q  <= kmc_pkg::RST_NUM_DIMS;
			cfg_nc_q  <= kmc_pkg::RST_NUM_CLUSTERS;
			cfg_mi_q  <= kmc_pkg::RST_MAX_ITERATIONS;
			cfg_tol_q <= kmc_pkg::RST_TOLERANCE;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				kmc_pkg::CFG_NUM_POINTS:     cfg_np_q  <= cfg_data[10:0];
				kmc_pkg::CFG_NUM_DIMS:       cfg_nd_q  <= cfg_data[3:0];
				kmc_pkg::CFG_NUM_CLUSTERS:   cfg_nc_q  <= cfg_data[3:0];
				kmc_pkg::CFG_MAX_ITERATIONS: cfg_mi_q  <= cfg_data[15:0];
				kmc_pkg::CFG_TOLERANCE:      cfg_tol_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// clamped run sizes: zero acts as one, cut to the build limits,
	// clusters also cut to the point count
	logic [31:0] np_c, nd_c, nc_c, nk_c;
	always_comb begin
		np_c = (cfg_np_q == '0) ? 32'd1
			: ((32'(cfg_np_q) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(cfg_np_q));
		nd_c = (cfg_nd_q == '0) ? 32'd1
			: ((32'(cfg_nd_q) > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : 32'(cfg_nd_q));
		nc_c = (cfg_nc_q == '0) ? 32'd1
			: ((32'(cfg_nc_q) > 32'(MAX_CLUSTERS)) ? 32'(MAX_CLUSTERS) : 32'(cfg_nc_q));
		if (nc_c > np_c) nc_c = np_c;
		nk_c = nc_c * nd_c;
	end

	// ---------------- datapath helpers ----------------
	logic [AD_W-1:0] st_addr;
	logic [CA_W-1:0] cent_addr, sum_addr, sa;
	logic signed [CW:0]     diff;
	logic signed [2*CW+1:0] sq;
	logic [DIST_W-1:0]      tot;
	logic                   better;
	logic [SUM_W-1:0]       sum_mag;
	logic [CW-1:0]          q16;
	logic signed [CW-1:0]   newv;
	logic signed [CW:0]     mvd;
	logic [CW:0]            mv_mag;
	logic                   moved;
	logic                   conv_now;
	logic [PTS_W:0]         shifted;
	logic                   ge;
	logic                   last_k;
	logic                   done_run;

	assign sa = CA_W'(lb_q + CA_W'(d_q));

	always_comb begin
		unique case (state_q)
			kmc_pkg::S_SEED_RD, kmc_pkg::S_SEED_WR: st_addr = AD_W'(k_q);
			default:                                st_addr = AD_W'(pb_q + AD_W'(d_q));
		endcase
		unique case (state_q)
			kmc_pkg::S_ASG_RD, kmc_pkg::S_ASG_MUL, kmc_pkg::S_ASG_ACC: cent_addr = ca_q;
			default:                                                   cent_addr = k_q;
		endcase
		unique case (state_q)
			kmc_pkg::S_ACC_RD2, kmc_pkg::S_ACC_WR: sum_addr = sa;
			default:                               sum_addr = k_q;
		endcase
	end

	assign diff   = {store_rd_q[CW-1], store_rd_q} - {cent_rd_q[CW-1], cent_rd_q};
	assign sq     = diff * diff;
	assign tot    = dist_q + DIST_W'(prod_q);
	assign better = (c_q == '0) || (tot < best_q);

	assign sum_mag = sum_rd_q[SUM_W-1] ? SUM_W'(-sum_rd_q) : SUM_W'(sum_rd_q);
	assign q16     = dq_q[CW-1:0];
	assign newv    = zero_q ? cent_rd_q : (neg_q ? signed'(-q16) : signed'(q16));
	assign mvd     = {newv[CW-1], newv} - {cent_rd_q[CW-1], cent_rd_q};
	assign mv_mag  = mvd[CW] ? (CW+1)'(-mvd) : (CW+1)'(mvd);
	assign moved   = mv_mag > (CW+1)'(cfg_tol_q);
	assign conv_now = conv_q && !moved;
	assign last_k  = (k_q == nk_m1_q);
	assign done_run = conv_now || ((17'(iter_q) + 17'd1) >= limit_q);

	// restoring divider step
	assign shifted = {rem_q, dq_q[DIV_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= kmc_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kmc_pkg::S_IDLE:
				if (in_acc && in_data.last_coordinate) state_d = kmc_pkg::S_SEED_RD;
			kmc_pkg::S_SEED_RD: state_d = kmc_pkg::S_SEED_WR;
			kmc_pkg::S_SEED_WR: state_d = last_k ? kmc_pkg::S_ITER : kmc_pkg::S_SEED_RD;
			kmc_pkg::S_ITER:    state_d = kmc_pkg::S_ASG_RD;
			kmc_pkg::S_ASG_RD:  state_d = kmc_pkg::S_ASG_MUL;
			kmc_pkg::S_ASG_MUL: state_d = kmc_pkg::S_ASG_ACC;
			kmc_pkg::S_ASG_ACC: begin
				if (d_q == nd_m1_q && c_q == nc_m1_q && i_q == np_m1_q)
					state_d = kmc_pkg::S_CLR;
				else
					state_d = kmc_pkg::S_ASG_RD;
			end
			kmc_pkg::S_CLR:     state_d = last_k ? kmc_pkg::S_ACC_RD : kmc_pkg::S_CLR;
			kmc_pkg::S_ACC_RD:  state_d = kmc_pkg::S_ACC_LAB;
			kmc_pkg::S_ACC_LAB: state_d = kmc_pkg::S_ACC_RD2;
			kmc_pkg::S_ACC_RD2: state_d = kmc_pkg::S_ACC_WR;
			kmc_pkg::S_ACC_WR: begin
				if (d_q != nd_m1_q)      state_d = kmc_pkg::S_ACC_RD2;
				else if (i_q != np_m1_q) state_d = kmc_pkg::S_ACC_RD;
				else                     state_d = kmc_pkg::S_UPD_RD;
			end
			kmc_pkg::S_UPD_RD:  state_d = kmc_pkg::S_UPD_CHK;
			kmc_pkg::S_UPD_CHK:
				state_d = (cnt_q[c_q] == '0) ? kmc_pkg::S_UPD_WR : kmc_pkg::S_DIV;
			kmc_pkg::S_DIV: begin
				if (dcnt_q == '0)
					state_d = div_share_q ? kmc_pkg::S_OUT_RD : kmc_pkg::S_UPD_WR;
			end
			kmc_pkg::S_UPD_WR: begin
				if (!last_k)       state_d = kmc_pkg::S_UPD_RD;
				else if (done_run) state_d = kmc_pkg::S_BEST;
				else               state_d = kmc_pkg::S_ITER;
			end
			kmc_pkg::S_BEST:
				state_d = (c_q == nc_m1_q) ? kmc_pkg::S_OUT_SH : kmc_pkg::S_BEST;
			kmc_pkg::S_OUT_SH:  state_d = kmc_pkg::S_DIV;
			kmc_pkg::S_OUT_RD:  state_d = kmc_pkg::S_OUT_LD;
			kmc_pkg::S_OUT_LD:  state_d = kmc_pkg::S_OUT_WAIT;
			kmc_pkg::S_OUT_WAIT: begin
				if (out_acc) begin
					priority if (d_q == nd_m1_q && c_q == nc_m1_q) state_d = kmc_pkg::S_IDLE;
					else if (d_q == nd_m1_q)                        state_d = kmc_pkg::S_OUT_SH;
					else                                            state_d = kmc_pkg::S_OUT_RD;
				end
			end
			default: state_d = kmc_pkg::S_IDLE;
		endcase
	end

	// load position and output valid: control registers with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (in_data.last_coordinate)  lp_q <= '0;
				else if (32'(lp_q) < DEPTH)   lp_q <= lp_q + 1'b1;
			end
			if (state_q == kmc_pkg::S_OUT_LD) out_valid_q <= 1'b1;
			else if (out_acc)                 out_valid_q <= 1'b0;
		end
	end

	// counters and arithmetic registers, each set before it is used
	always_ff @(posedge clk) begin
		unique case (state_q)
			kmc_pkg::S_IDLE: begin
				if (in_acc && in_data.last_coordinate) begin
					np_q    <= PTS_W'(np_c);
					np_m1_q <= PI_W'(np_c - 32'd1);
					nd_q    <= DN_W'(nd_c);
					nd_m1_q <= DI_W'(nd_c - 32'd1);
					nc_m1_q <= LB_W'(nc_c - 32'd1);
					nk_m1_q <= CA_W'(nk_c - 32'd1);
					limit_q <= (cfg_mi_q == '0) ? 17'd1 : 17'(cfg_mi_q);
					k_q     <= '0;
					iter_q  <= '0;
				end
			end
			kmc_pkg::S_SEED_WR: k_q <= k_q + 1'b1;
			kmc_pkg::S_ITER: begin
				i_q    <= '0;
				pb_q   <= '0;
				c_q    <= '0;
				d_q    <= '0;
				ca_q   <= '0;
				dist_q <= '0;
				conv_q <= 1'b1;
			end
			kmc_pkg::S_ASG_MUL: prod_q <= SQ_W'(sq);
			kmc_pkg::S_ASG_ACC: begin
				ca_q <= ca_q + 1'b1;
				if (d_q == nd_m1_q) begin
					d_q    <= '0;
					dist_q <= '0;
					if (better) begin
						best_q <= tot;
						lab_q  <= c_q;
					end
					if (c_q == nc_m1_q) begin
						c_q  <= '0;
						ca_q <= '0;
						i_q  <= i_q + 1'b1;
						pb_q <= AD_W'(pb_q + AD_W'(nd_q));
						if (i_q == np_m1_q) begin
							k_q <= '0;
							for (int n = 0; n < MAX_CLUSTERS; n++) cnt_q[n] <= '0;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end else begin
					d_q    <= d_q + 1'b1;
					dist_q <= tot;
				end
			end
			kmc_pkg::S_CLR: begin
				k_q <= k_q + 1'b1;
				i_q  <= '0;
				pb_q <= '0;
				d_q  <= '0;
			end
			kmc_pkg::S_ACC_LAB: begin
				lb_q <= CA_W'(32'(lbl_rd_q) * 32'(nd_q));
				cnt_q[lbl_rd_q] <= cnt_q[lbl_rd_q] + 1'b1;
				d_q <= '0;
			end
			kmc_pkg::S_ACC_WR: begin
				if (d_q == nd_m1_q) begin
					d_q  <= '0;
					i_q  <= i_q + 1'b1;
					pb_q <= AD_W'(pb_q + AD_W'(nd_q));
					if (i_q == np_m1_q) begin
						k_q <= '0;
						c_q <= '0;
					end
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			kmc_pkg::S_UPD_CHK: begin
				zero_q      <= (cnt_q[c_q] == '0);
				neg_q       <= sum_rd_q[SUM_W-1];
				dq_q        <= DIV_W'(sum_mag);
				den_q       <= cnt_q[c_q];
				rem_q       <= '0;
				dcnt_q      <= DC_W'(DIV_W - 1);
				div_share_q <= 1'b0;
			end
			kmc_pkg::S_DIV: begin
				rem_q  <= ge ? PTS_W'(shifted - {1'b0, den_q}) : PTS_W'(shifted);
				dq_q   <= {dq_q[DIV_W-2:0], ge};
				dcnt_q <= dcnt_q - 1'b1;
			end
			kmc_pkg::S_UPD_WR: begin
				conv_q <= conv_now;
				k_q    <= k_q + 1'b1;
				if (d_q == nd_m1_q) begin
					d_q <= '0;
					c_q <= c_q + 1'b1;
				end else begin
					d_q <= d_q + 1'b1;
				end
				if (last_k) begin
					c_q      <= '0;
					d_q      <= '0;
					best_n_q <= '0;
					best_c_q <= '0;
					iter_q   <= iter_q + 1'b1;
				end
			end
			kmc_pkg::S_BEST: begin
				if (cnt_q[c_q] > best_n_q) begin
					best_n_q <= cnt_q[c_q];
					best_c_q <= c_q;
				end
				c_q <= c_q + 1'b1;
				if (c_q == nc_m1_q) begin
					c_q <= '0;
					d_q <= '0;
					k_q <= '0;
				end
			end
			kmc_pkg::S_OUT_SH: begin
				dq_q        <= DIV_W'(cnt_q[c_q]) * DIV_W'(kmc_pkg::SHARE_SCALE);
				den_q       <= np_q;
				rem_q       <= '0;
				dcnt_q      <= DC_W'(DIV_W - 1);
				div_share_q <= 1'b1;
			end
			kmc_pkg::S_OUT_LD: begin
				out_q.cluster_index    <= 3'(c_q);
				out_q.dim_index        <= 3'(d_q);
				out_q.centroid_value   <= cent_rd_q;
				out_q.share_hundredths <= dq_q[kmc_pkg::SHARE_W-1:0];
				out_q.is_most_frequent <= (c_q == best_c_q);
				out_q.last_result      <= (c_q == nc_m1_q) && (d_q == nd_m1_q);
			end
			kmc_pkg::S_OUT_WAIT: begin
				if (out_acc) begin
					k_q <= k_q + 1'b1;
					if (d_q == nd_m1_q) begin
						d_q <= '0;
						c_q <= c_q + 1'b1;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (in_acc && 32'(lp_q) < DEPTH) store_mem[lp_q[AD_W-1:0]] <= in_data.coordinate;
		store_rd_q <= store_mem[st_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == kmc_pkg::S_ASG_ACC && d_q == nd_m1_q && c_q == nc_m1_q)
			lbl_mem[i_q] <= better ? c_q : lab_q;
		lbl_rd_q <= lbl_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == kmc_pkg::S_SEED_WR)     cent_mem[k_q] <= store_rd_q;
		else if (state_q == kmc_pkg::S_UPD_WR) cent_mem[k_q] <= newv;
		cent_rd_q <= cent_mem[cent_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == kmc_pkg::S_CLR)         sum_mem[k_q] <= '0;
		else if (state_q == kmc_pkg::S_ACC_WR) sum_mem[sa] <= sum_rd_q + SUM_W'(store_rd_q);
		sum_rd_q <= sum_mem[sum_addr];
	end

	// ---------------- assertions ----------------
	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == kmc_pkg::S_OUT_WAIT)
		else $error("result beat outside output wait");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid_q)
		else $error("input open while a result is pending");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kmc_pkg::S_DIV |=> (state_q == kmc_pkg::S_DIV
			|| state_q == kmc_pkg::S_UPD_WR || state_q == kmc_pkg::S_OUT_RD))
		else $error("divider left to a wrong state");

	a_dim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kmc_pkg::S_ASG_ACC |-> d_q <= nd_m1_q)
		else $error("dimension counter past last dimension");

endmodule

>>> tb/testbench.sv
// testbench: checks kmeans_clustering_top against its own k-means predictor.
// Directed rows, one clamped-size run, then random runs. Depends on kmc_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int P_MAX      = 1024;
	localparam int D_MAX      = 8;
	localparam int C_MAX      = 8;
	localparam int STORE_SIZE = P_MAX * D_MAX;
	localparam int IDLE_LIMIT = 1000000;   // cycles with no beat on any channel
	localparam int SETTLE     = 20;        // quiet cycles before a register write
	localparam int RANDOM_BEATS = 150;

	typedef enum logic [1:0] {ROW_CFG, ROW_BEAT} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [15:0] val;    // register data or coordinate
		bit          last;
		bit          whole;  // single-point run: result is the point itself, full share
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	kmc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	kmc_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [kmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	kmeans_clustering_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: registers, point store and centroid memories
	// ---------------------------------------------------------------
	logic [10:0] reg_points = kmc_pkg::RST_NUM_POINTS;
	logic [3:0]  reg_dims = kmc_pkg::RST_NUM_DIMS;
	logic [3:0]  reg_clusters = kmc_pkg::RST_NUM_CLUSTERS;
	logic [15:0] reg_iters = kmc_pkg::RST_MAX_ITERATIONS;
	logic [14:0] reg_tol = kmc_pkg::RST_TOLERANCE;

	int     points[STORE_SIZE];
	int     labels[P_MAX];
	int     cent_old[C_MAX*D_MAX];
	int     cent_new[C_MAX*D_MAX];
	longint sums[C_MAX*D_MAX];
	int     members[C_MAX];
	int     load_pos = 0;
	int     written_hi = 0;    // store entries [0, written_hi) hold real data

	kmc_pkg::out_t expected_centroids[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     long_hold_req = 0;

	function automatic int clamp_reg(int v, int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void set_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			kmc_pkg::CFG_NUM_POINTS:     reg_points = v[10:0];
			kmc_pkg::CFG_NUM_DIMS:       reg_dims = v[3:0];
			kmc_pkg::CFG_NUM_CLUSTERS:   reg_clusters = v[3:0];
			kmc_pkg::CFG_MAX_ITERATIONS: reg_iters = v;
			kmc_pkg::CFG_TOLERANCE:      reg_tol = v[14:0];
			default: ;
		endcase
	endfunction

	// Lloyd iterations on the stored points, then queue one result per
	// centroid coordinate (or the typed-in one for single-point rows).
	function automatic void cluster_and_emit(bit whole, logic [15:0] whole_val);
		int np, nd, nc, limit, it, i, c, d, k, lab, best_c, best_n;
		longint best, sqd, diff, mv;
		bit converged;
		kmc_pkg::out_t r;
		np = clamp_reg(reg_points, P_MAX);
		nd = clamp_reg(reg_dims, D_MAX);
		nc = clamp_reg(reg_clusters, C_MAX);
		if (nc > np) nc = np;
		limit = (reg_iters == 0) ? 1 : reg_iters;
		for (i = 0; i < nc*nd; i++) begin
			cent_old[i] = points[i];
			cent_new[i] = points[i];
		end
		for (it = 0; it < limit; it++) begin
			converged = 1;
			for (i = 0; i < np; i++) begin
				lab = 0;
				best = 0;
				for (c = 0; c < nc; c++) begin
					sqd = 0;
					for (d = 0; d < nd; d++) begin
						diff = longint'(points[i*nd+d]) - longint'(cent_old[c*nd+d]);
						sqd += diff * diff;
					end
					// strict less-than: lowest index keeps a tie
					if (c == 0 || sqd < best) begin
						best = sqd;
						lab = c;
					end
				end
				labels[i] = lab;
			end
			for (k = 0; k < C_MAX*D_MAX; k++) sums[k] = 0;
			for (c = 0; c < C_MAX; c++) members[c] = 0;
			for (i = 0; i < np; i++) begin
				members[labels[i]]++;
				for (d = 0; d < nd; d++) sums[labels[i]*nd+d] += points[i*nd+d];
			end
			for (c = 0; c < nc; c++) begin
				for (d = 0; d < nd; d++) begin
					k = c*nd + d;
					// empty cluster holds its centroid; division truncates toward zero
					cent_new[k] = (members[c] != 0) ? int'(sums[k] / members[c]) : cent_old[k];
					mv = longint'(cent_new[k]) - longint'(cent_old[k]);
					if (mv < 0) mv = -mv;
					if (mv > reg_tol) converged = 0;
				end
			end
			if (converged) break;
			for (k = 0; k < C_MAX*D_MAX; k++) cent_old[k] = cent_new[k];
		end
		best_c = 0;
		best_n = 0;
		for (c = 0; c < nc; c++)
			if (members[c] > best_n) begin
				best_n = members[c];
				best_c = c;
			end
		if (whole) begin
			r.cluster_index = '0;
			r.dim_index = '0;
			r.centroid_value = whole_val;
			r.share_hundredths = 14'd10000;
			r.is_most_frequent = 1'b1;
			r.last_result = 1'b1;
			expected_centroids.push_back(r);
			return;
		end
		for (c = 0; c < nc; c++)
			for (d = 0; d < nd; d++) begin
				r.cluster_index = c[2:0];
				r.dim_index = d[2:0];
				r.centroid_value = cent_new[c*nd+d][15:0];
				r.share_hundredths = 14'((longint'(members[c]) * kmc_pkg::SHARE_SCALE) / np);
				r.is_most_frequent = (c == best_c);
				r.last_result = (c == nc-1) && (d == nd-1);
				expected_centroids.push_back(r);
			end
	endfunction

	function automatic void absorb_beat(kmc_pkg::in_t b, bit whole);
		if (load_pos < STORE_SIZE) begin
			points[load_pos] = int'(b.coordinate);
			load_pos++;
			if (load_pos > written_hi) written_hi = load_pos;
		end
		if (b.last_coordinate) begin
			cluster_and_emit(whole, b.coordinate);
			load_pos = 0;
		end
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	int burst_left = 0;

	task automatic send_beat(logic [15:0] coord, bit last, bit whole);
		kmc_pkg::in_t b;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		b.coordinate = coord;
		b.last_coordinate = last;
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		absorb_beat(b, whole);
	endtask

	// sender holds off until every queued result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_centroids.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// valid goes low after each write before the task returns, so it never toggles twice in a step
	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		set_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Receiver: check each result beat, stall on its own pattern
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		kmc_pkg::out_t e;
		bit stall_next;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_centroids.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", out_data);
				end else begin
					e = expected_centroids.pop_front();
					if (out_data.cluster_index !== e.cluster_index
							|| out_data.dim_index !== e.dim_index
							|| out_data.centroid_value !== e.centroid_value
							|| out_data.share_hundredths !== e.share_hundredths
							|| out_data.is_most_frequent !== e.is_most_frequent
							|| out_data.last_result !== e.last_result) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p got %p", e, out_data);
					end
				end
			end
			// long hold-off once, so the block backs up into its input
			if (long_hold_req && out_valid && hold_left == 0) begin
				long_hold_req = 0;
				hold_left = 600;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				default: stall_next = ($urandom_range(0, 3) != 0);
			endcase
			out_stall <= stall_next;
		end
	end

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	row_t dir_rows[$];

	initial begin
		int r, run, np, nd, nc, n, len, beats_done;
		bit keep_cfg;
		dir_rows = '{
			// one point, one cluster, zero iterations acting as one
			'{ROW_CFG,  kmc_pkg::CFG_NUM_POINTS,     16'd1,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_NUM_DIMS,       16'd1,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_NUM_CLUSTERS,   16'd1,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_MAX_ITERATIONS, 16'd0,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_TOLERANCE,      16'd0,     0, 0},
			'{ROW_BEAT, 3'd0,                        16'h7FFF,  1, 1},
			'{ROW_BEAT, 3'd0,                        16'h8000,  1, 1},
			'{ROW_BEAT, 3'd0,                        16'h0000,  1, 1},
			// point count of zero is raised to one
			'{ROW_CFG,  kmc_pkg::CFG_NUM_POINTS,     16'd0,     0, 0},
			'{ROW_BEAT, 3'd0,                        16'hFFFF,  1, 1},
			'{ROW_BEAT, 3'd0,                        16'h0001,  1, 1},
			// identical points: distance ties, second cluster empty
			'{ROW_CFG,  kmc_pkg::CFG_NUM_POINTS,     16'd3,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_NUM_CLUSTERS,   16'd2,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_MAX_ITERATIONS, 16'hFFFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h0500,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h0500,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h0500,  1, 0},
			// corner points, tolerance at its top (upper bit masked off)
			'{ROW_CFG,  kmc_pkg::CFG_NUM_POINTS,     16'd4,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_NUM_DIMS,       16'd2,     0, 0},
			'{ROW_CFG,  kmc_pkg::CFG_TOLERANCE,      16'hFFFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h8000,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h8000,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h7FFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h7FFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h8000,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h7FFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h7FFF,  0, 0},
			'{ROW_BEAT, 3'd0,                        16'h8000,  1, 0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else
				send_beat(dir_rows[i].val, dir_rows[i].last, dir_rows[i].whole);
		end

		// oversized dimension and cluster counts clamp to the maxima
		drain();
		write_reg(kmc_pkg::CFG_NUM_POINTS, 16'd9);
		write_reg(kmc_pkg::CFG_NUM_DIMS, 16'd15);
		write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 16'd15);
		write_reg(kmc_pkg::CFG_MAX_ITERATIONS, 16'd0);
		write_reg(kmc_pkg::CFG_TOLERANCE, 16'd0);
		for (n = 0; n < 9 * D_MAX; n++)
			send_beat(16'($urandom), n == 9 * D_MAX - 1, 0);

		// random runs, mostly well formed, some over- or under-filled
		beats_done = 0;
		run = 0;
		while (beats_done < RANDOM_BEATS || run < 5) begin
			keep_cfg = (run == 4);
			if (!keep_cfg) begin
				drain();
				np = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				nd = (np > 12) ? $urandom_range(1, 2)
					: (($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4));
				nc = $urandom_range(1, (np < C_MAX) ? np : C_MAX);
				write_reg(kmc_pkg::CFG_NUM_POINTS, 16'(np));
				write_reg(kmc_pkg::CFG_NUM_DIMS, 16'(nd));
				write_reg(kmc_pkg::CFG_NUM_CLUSTERS, 16'(nc));
				write_reg(kmc_pkg::CFG_MAX_ITERATIONS, 16'($urandom_range(1, 20)));
				case ($urandom_range(0, 3))
					0, 1: write_reg(kmc_pkg::CFG_TOLERANCE, 16'd0);
					2: write_reg(kmc_pkg::CFG_TOLERANCE, 16'($urandom_range(1, 64)));
					default: write_reg(kmc_pkg::CFG_TOLERANCE, 16'($urandom_range(0, 32767)));
				endcase
			end
			// results of this run get held off while the next run keeps sending
			if (run == 3) long_hold_req = 1;
			len = np * nd;
			case ($urandom_range(0, 9))
				0: len = len + $urandom_range(1, 5);
				1: len = $urandom_range(1, len);
				default: ;
			endcase
			if (len < np*nd && written_hi < np*nd) len = np*nd;
			// clustered random content now and then, so iterations move
			for (n = 0; n < len; n++) begin
				r = $urandom_range(0, 3);
				send_beat((r == 0) ? 16'($urandom_range(0, 15) << 12 | $urandom_range(0, 255))
					: 16'($urandom), n == len - 1, 0);
			end
			beats_done += len;
			run++;
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_centroids.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
